// ===== rtl/fsrp_pkg.sv =====
// Shared types and constants for the free slot rectangle placer.
package fsrp_pkg;

  localparam int MAX_RECTS = 32;
  localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  // One obstacle entry as stored in the table RAM: {left, top, width, height}.
  localparam int POS_W = 13;
  localparam int LEN_W = 12;
  localparam int ENT_W = 2 * POS_W + 2 * LEN_W;

  // Working width for coordinate sums and compares.
  localparam int CRD_W = 16;
  localparam logic signed [CRD_W-1:0] PLACE_MARGIN = 16'sd5;
  localparam logic signed [CRD_W-1:0] PLACE_STEP   = 16'sd10;

  typedef struct packed {
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] top;
    logic [LEN_W-1:0]        width;
    logic [LEN_W-1:0]        height;
  } fsrp_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COND = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } fsrp_state_t;

  typedef enum logic {
    EDGE_RIGHT  = 1'b0,
    EDGE_BOTTOM = 1'b1
  } fsrp_edge_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PLACE = 1'b1;

  localparam logic REG_DISPLAY_WIDTH  = 1'b0;
  localparam logic REG_DISPLAY_HEIGHT = 1'b1;

endpackage

// ===== rtl/fsrp_ram.sv =====
// Generic single write port RAM with registered read.
module fsrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/free_slot_rect_placer_top.sv =====
// Top level of the free slot rectangle placer: obstacle table and edge search sequencer.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   func slot obs_* want_w want_h default_x default_y
//  out      output     out_valid / out_ready place_x place_y found
//  cfg      input      cfg_valid / cfg_ready cfg_index cfg_data
//
// A write item goes from idle to the finish state. A place item runs, for every candidate
// tried, a range test and a table scan over up to MAX_RECTS entries, plus one more range test
// for each edge that runs out; the scan reads one table entry a cycle through the RAM read
// port and tests it in one compare unit.
// Reset sets the display size to 1024 by 768 and clears the live bits and all control state.
// A finished item waits in its last state while the output register holds an untaken result;
// in_ready is high whenever the sequencer is idle, also while out_valid is stalled.
// cfg_ready is always high.
module free_slot_rect_placer_top
  import fsrp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic [4:0]              slot,
  input  logic signed [POS_W-1:0] obs_x,
  input  logic signed [POS_W-1:0] obs_y,
  input  logic [LEN_W-1:0]        obs_w,
  input  logic [LEN_W-1:0]        obs_h,
  input  logic                    obs_valid,
  input  logic [LEN_W-1:0]        want_w,
  input  logic [LEN_W-1:0]        want_h,
  input  logic signed [POS_W-1:0] default_x,
  input  logic signed [POS_W-1:0] default_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] place_x,
  output logic signed [POS_W-1:0] place_y,
  output logic                    found,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [LEN_W-1:0]        cfg_data
);

  fsrp_state_t state, state_next;
  fsrp_edge_t  phase, phase_next;

  logic [LEN_W-1:0] dw, dh;
  logic [MAX_RECTS-1:0] live;

  logic signed [CRD_W-1:0] x, x_next, y, y_next;
  logic signed [CRD_W-1:0] ylim, ylim_next, xstart, xstart_next;
  logic [LEN_W-1:0]        want_w_q, want_w_next, want_h_q, want_h_next;
  logic signed [POS_W-1:0] def_x, def_x_next, def_y, def_y_next;
  logic [IDX_W-1:0]        rd_idx, rd_idx_next, cmp_idx, cmp_idx_next;
  logic                    issue_done, issue_done_next, cmp_vld, cmp_vld_next;
  logic signed [POS_W-1:0] res_x, res_x_next, res_y, res_y_next;
  logic                    res_found, res_found_next;

  logic              accept, wr_en, load_out;
  logic [IDX_W-1:0]  wr_idx;
  fsrp_entry_t       wr_ent, rd_ent;
  logic [ENT_W-1:0]  rd_raw;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RECTS - 1);

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign wr_en     = accept && (func == FUNC_WRITE) && (32'(slot) < MAX_RECTS);
  assign wr_idx    = IDX_W'(slot);
  assign load_out  = (state == ST_FIN) && (!out_valid || out_ready);

  assign wr_ent.left   = obs_x;
  assign wr_ent.top    = obs_y;
  assign wr_ent.width  = obs_w;
  assign wr_ent.height = obs_h;

  fsrp_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_RECTS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata(wr_ent),
    .raddr(rd_idx),
    .rdata(rd_raw)
  );

  assign rd_ent = fsrp_entry_t'(rd_raw);

  // Overlap of the candidate box with the entry read last cycle, grown by the margin.
  logic signed [CRD_W-1:0] ent_l, ent_t, l_m, r_p, t_m, b_p, xw, yh;
  logic hit;

  always_comb begin
    ent_l = {{(CRD_W-POS_W){rd_ent.left[POS_W-1]}}, rd_ent.left};
    ent_t = {{(CRD_W-POS_W){rd_ent.top[POS_W-1]}}, rd_ent.top};
    l_m   = ent_l - PLACE_MARGIN;
    r_p   = ent_l + {{(CRD_W-LEN_W){1'b0}}, rd_ent.width} + PLACE_MARGIN;
    t_m   = ent_t - PLACE_MARGIN;
    b_p   = ent_t + {{(CRD_W-LEN_W){1'b0}}, rd_ent.height} + PLACE_MARGIN;
    xw    = x + {{(CRD_W-LEN_W){1'b0}}, want_w_q};
    yh    = y + {{(CRD_W-LEN_W){1'b0}}, want_h_q};
    hit   = live[cmp_idx] && (l_m < xw) && (r_p > x) && (t_m < yh) && (b_p > y);
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    x_next          = x;
    y_next          = y;
    ylim_next       = ylim;
    xstart_next     = xstart;
    want_w_next     = want_w_q;
    want_h_next     = want_h_q;
    def_x_next      = def_x;
    def_y_next      = def_y;
    rd_idx_next     = rd_idx;
    issue_done_next = issue_done;
    cmp_vld_next    = 1'b0;
    cmp_idx_next    = cmp_idx;
    res_x_next      = res_x;
    res_y_next      = res_y;
    res_found_next  = res_found;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_PLACE) begin
            want_w_next = want_w;
            want_h_next = want_h;
            def_x_next  = default_x;
            def_y_next  = default_y;
            xstart_next = {{(CRD_W-LEN_W){1'b0}}, dw} - {{(CRD_W-LEN_W){1'b0}}, want_w};
            x_next      = {{(CRD_W-LEN_W){1'b0}}, dw} - {{(CRD_W-LEN_W){1'b0}}, want_w};
            ylim_next   = {{(CRD_W-LEN_W){1'b0}}, dh} - {{(CRD_W-LEN_W){1'b0}}, want_h};
            y_next      = '0;
            phase_next  = EDGE_RIGHT;
            state_next  = ST_COND;
          end else begin
            res_x_next     = '0;
            res_y_next     = '0;
            res_found_next = 1'b0;
            state_next     = ST_FIN;
          end
        end
      end
      ST_COND: begin
        rd_idx_next     = '0;
        issue_done_next = 1'b0;
        if (phase == EDGE_RIGHT) begin
          if (y < ylim) begin
            state_next = ST_SCAN;
          end else begin
            // Right edge exhausted: move to the bottom edge.
            phase_next = EDGE_BOTTOM;
            y_next     = ylim;
            x_next     = xstart;
          end
        end else begin
          if (x > 0) begin
            state_next = ST_SCAN;
          end else begin
            res_x_next     = def_x;
            res_y_next     = def_y;
            res_found_next = 1'b0;
            state_next     = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one table read a cycle; test the entry read last cycle.
        if (!issue_done) begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = rd_idx;
          if (rd_idx == LAST_IDX) begin
            issue_done_next = 1'b1;
          end else begin
            rd_idx_next = rd_idx + IDX_W'(1);
          end
        end
        if (cmp_vld) begin
          if (hit) begin
            cmp_vld_next = 1'b0;
            if (phase == EDGE_RIGHT) begin
              y_next = y + PLACE_STEP;
            end else begin
              x_next = x - PLACE_STEP;
            end
            state_next = ST_COND;
          end else if (cmp_idx == LAST_IDX) begin
            cmp_vld_next   = 1'b0;
            res_x_next     = x[POS_W-1:0];
            res_y_next     = y[POS_W-1:0];
            res_found_next = 1'b1;
            state_next     = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= EDGE_RIGHT;
      cmp_vld    <= 1'b0;
      issue_done <= 1'b0;
      rd_idx     <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      cmp_vld    <= cmp_vld_next;
      issue_done <= issue_done_next;
      rd_idx     <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    x         <= x_next;
    y         <= y_next;
    ylim      <= ylim_next;
    xstart    <= xstart_next;
    want_w_q  <= want_w_next;
    want_h_q  <= want_h_next;
    def_x     <= def_x_next;
    def_y     <= def_y_next;
    cmp_idx   <= cmp_idx_next;
    res_x     <= res_x_next;
    res_y     <= res_y_next;
    res_found <= res_found_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (wr_en) begin
      live[wr_idx] <= obs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dw <= 12'd1024;
      dh <= 12'd768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DISPLAY_WIDTH:  dw <= cfg_data;
        REG_DISPLAY_HEIGHT: dh <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold the result until the output transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      place_x <= res_x;
      place_y <= res_y;
      found   <= res_found;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted again before the item finished");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("finished result not presented");

  a_cmp_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (state == ST_SCAN) && ($past(state) == ST_SCAN))
    else $error("table compare outside scan");
`endif

endmodule

// ===== bench/tb_free_slot_rect_placer_top.sv =====
// Self-checking testbench for the free slot rectangle placer: directed and random traffic.
module tb_free_slot_rect_placer_top;
  import fsrp_pkg::*;

  typedef struct {
    logic                    func;
    logic [4:0]              slot;
    logic signed [POS_W-1:0] obs_x;
    logic signed [POS_W-1:0] obs_y;
    logic [LEN_W-1:0]        obs_w;
    logic [LEN_W-1:0]        obs_h;
    logic                    obs_valid;
    logic [LEN_W-1:0]        want_w;
    logic [LEN_W-1:0]        want_h;
    logic signed [POS_W-1:0] default_x;
    logic signed [POS_W-1:0] default_y;
  } request_t;

  typedef struct packed {
    logic signed [POS_W-1:0] place_x;
    logic signed [POS_W-1:0] place_y;
    logic                    found;
  } answer_t;

  // Mirrors the obstacle table and display size, and holds the answers still owed.
  class placement_tracker;
    int          disp_w;
    int          disp_h;
    fsrp_entry_t rects[MAX_RECTS];
    bit          live[MAX_RECTS];
    answer_t     due_answers[$];
    int          errors;
    int          checked;
    int          spots_found;

    function new();
      disp_w = 1024;
      disp_h = 768;
      foreach (live[i]) live[i] = 1'b0;
      errors = 0;
      checked = 0;
      spots_found = 0;
    endfunction

    function void set_register(logic idx, logic [LEN_W-1:0] val);
      if (idx == REG_DISPLAY_WIDTH) disp_w = int'(val);
      else disp_h = int'(val);
    endfunction

    // Box at (x,y) of w by h must miss every live obstacle grown by the margin.
    function bit spot_clear(int x, int y, int w, int h);
      int l, t, ow, oh, m;
      m = int'(PLACE_MARGIN);
      for (int i = 0; i < MAX_RECTS; i++) begin
        if (live[i]) begin
          l  = int'($signed(rects[i].left));
          t  = int'($signed(rects[i].top));
          ow = int'(rects[i].width);
          oh = int'(rects[i].height);
          if (l - m < x + w && l + ow + m > x &&
              t - m < y + h && t + oh + m > y)
            return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_request(request_t rq);
      answer_t a;
      int      w, h, x, y;
      bit      ok;
      a = '0;
      if (rq.func == FUNC_WRITE) begin
        if (rq.slot < MAX_RECTS) begin
          rects[rq.slot].left   = rq.obs_x;
          rects[rq.slot].top    = rq.obs_y;
          rects[rq.slot].width  = rq.obs_w;
          rects[rq.slot].height = rq.obs_h;
          live[rq.slot]         = rq.obs_valid;
        end
      end else begin
        w  = int'(rq.want_w);
        h  = int'(rq.want_h);
        ok = 1'b0;
        a.place_x = rq.default_x;
        a.place_y = rq.default_y;
        // walk down the right edge first
        x = disp_w - w;
        y = 0;
        while (!ok && y < disp_h - h) begin
          if (spot_clear(x, y, w, h)) ok = 1'b1;
          else y += int'(PLACE_STEP);
        end
        // then leftward along the bottom edge
        if (!ok) begin
          y = disp_h - h;
          x = disp_w - w;
          while (!ok && x > 0) begin
            if (spot_clear(x, y, w, h)) ok = 1'b1;
            else x -= int'(PLACE_STEP);
          end
        end
        if (ok) begin
          a.place_x = POS_W'(x);
          a.place_y = POS_W'(y);
          a.found   = 1'b1;
        end
      end
      due_answers.push_back(a);
    endfunction

    function void flag_field(string name, int want, int got);
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      checked++;
      if (got.found === 1'b1) spots_found++;
      if (due_answers.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result x=%0d y=%0d found=%0d, expected none",
                   $time, got.place_x, got.place_y, got.found);
        return;
      end
      want = due_answers.pop_front();
      if (got.place_x !== want.place_x)
        flag_field("place_x", int'(want.place_x), int'(got.place_x));
      if (got.place_y !== want.place_y)
        flag_field("place_y", int'(want.place_y), int'(got.place_y));
      if (got.found !== want.found)
        flag_field("found", int'(want.found), int'(got.found));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    func = FUNC_WRITE;
  logic [4:0]              slot = '0;
  logic signed [POS_W-1:0] obs_x = '0;
  logic signed [POS_W-1:0] obs_y = '0;
  logic [LEN_W-1:0]        obs_w = '0;
  logic [LEN_W-1:0]        obs_h = '0;
  logic                    obs_valid = 1'b0;
  logic [LEN_W-1:0]        want_w = '0;
  logic [LEN_W-1:0]        want_h = '0;
  logic signed [POS_W-1:0] default_x = '0;
  logic signed [POS_W-1:0] default_y = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] place_x;
  logic signed [POS_W-1:0] place_y;
  logic                    found;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = REG_DISPLAY_WIDTH;
  logic [LEN_W-1:0]        cfg_data = '0;

  placement_tracker tracker;
  int  cur_w = 1024;
  int  cur_h = 768;
  bit  quiet_sender = 1'b0;
  bit  hold_out = 1'b0;
  int  n_items = 0;
  int  n_place = 0;

  free_slot_rect_placer_top uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #250_000_000;
    $display("Timeout: %0d results still outstanding", tracker.due_answers.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic int clamp_pos(int v);
    return (v > 4095) ? 4095 : v;
  endfunction

  function automatic request_t noise_request();
    request_t rq;
    rq.func      = 1'($urandom);
    rq.slot      = 5'($urandom);
    rq.obs_x     = POS_W'($urandom);
    rq.obs_y     = POS_W'($urandom);
    rq.obs_w     = LEN_W'($urandom);
    rq.obs_h     = LEN_W'($urandom);
    rq.obs_valid = 1'($urandom);
    rq.want_w    = LEN_W'($urandom);
    rq.want_h    = LEN_W'($urandom);
    rq.default_x = POS_W'($urandom);
    rq.default_y = POS_W'($urandom);
    return rq;
  endfunction

  function automatic request_t write_item(int s, int x, int y, int w, int h, bit v);
    request_t rq;
    rq = noise_request();
    rq.func      = FUNC_WRITE;
    rq.slot      = 5'(s);
    rq.obs_x     = POS_W'(x);
    rq.obs_y     = POS_W'(y);
    rq.obs_w     = LEN_W'(w);
    rq.obs_h     = LEN_W'(h);
    rq.obs_valid = v;
    return rq;
  endfunction

  function automatic request_t place_item(int w, int h, int dx, int dy);
    request_t rq;
    rq = noise_request();
    rq.func      = FUNC_PLACE;
    rq.want_w    = LEN_W'(w);
    rq.want_h    = LEN_W'(h);
    rq.default_x = POS_W'(dx);
    rq.default_y = POS_W'(dy);
    return rq;
  endfunction

  // Obstacles and boxes scaled to the current display, plus some free slots and raw noise.
  function automatic request_t rand_request();
    request_t rq;
    int       r;
    rq = noise_request();
    r  = $urandom_range(0, 99);
    if (r < 55) begin
      rq.func      = FUNC_WRITE;
      rq.obs_x     = POS_W'(clamp_pos(int'($urandom_range(0, cur_w + 30)) - 20));
      rq.obs_y     = POS_W'(clamp_pos(int'($urandom_range(0, cur_h + 30)) - 20));
      rq.obs_w     = LEN_W'($urandom_range(0, cur_w / 3 + 1));
      rq.obs_h     = LEN_W'($urandom_range(0, cur_h / 3 + 1));
      rq.obs_valid = ($urandom_range(0, 7) != 0);
    end else if (r < 62) begin
      rq.func      = FUNC_WRITE;
      rq.obs_valid = 1'b0;
    end else if (r < 92) begin
      rq.func   = FUNC_PLACE;
      rq.want_w = LEN_W'($urandom_range(0, cur_w / 2 + 1));
      rq.want_h = LEN_W'($urandom_range(0, cur_h / 2 + 1));
    end
    return rq;
  endfunction

  task automatic idle_sender();
    int n;
    n = quiet_sender ? 0 : pick_gap();
    if (n > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_request(request_t rq);
    idle_sender();
    @(negedge clk);
    func      <= rq.func;
    slot      <= rq.slot;
    obs_x     <= rq.obs_x;
    obs_y     <= rq.obs_y;
    obs_w     <= rq.obs_w;
    obs_h     <= rq.obs_h;
    obs_valid <= rq.obs_valid;
    want_w    <= rq.want_w;
    want_h    <= rq.want_h;
    default_x <= rq.default_x;
    default_y <= rq.default_y;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_request(rq);
    n_items++;
    if (rq.func == FUNC_PLACE) n_place++;
  endtask

  task automatic write_register(logic idx, logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_register(idx, val);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic drain_answers();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.due_answers.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, calm stretches, and one long hold on request.
  initial begin
    int      stall_left;
    int      calm;
    answer_t seen;
    stall_left = 0;
    calm = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (calm > 0) calm--;
        else begin
          stall_left = pick_gap();
          if (stall_left > 10) calm = $urandom_range(0, 80);
        end
      end
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        seen.place_x = place_x;
        seen.place_y = place_y;
        seen.found   = found;
        tracker.check_answer(seen);
      end
    end
  end

  initial begin
    int n_rand;
    int phase;
    int count;
    tracker = new();
    n_rand = 0;
    phase = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part at the reset display size of 1024 by 768.
    send_request(place_item(100, 50, 7, -9));
    send_request(write_item(0, 900, 0, 124, 100, 1'b1));
    send_request(place_item(100, 50, 0, 0));
    send_request(write_item(31, -4096, -4096, 4095, 4095, 1'b1));
    send_request(write_item(1, 4095, 4095, 0, 0, 1'b1));
    send_request(place_item(0, 0, -4096, 4095));
    // box larger than the display: both edges empty
    send_request(place_item(4095, 4095, 4095, -4096));
    // cover the whole display: nothing fits
    send_request(write_item(2, -10, -10, 4095, 4095, 1'b1));
    send_request(place_item(100, 50, 123, 456));
    send_request(write_item(2, 0, 0, 0, 0, 1'b0));
    send_request(place_item(100, 50, -1, -1));
    // block the right edge column so the bottom edge is searched
    send_request(write_item(3, 1000, -10, 24, 800, 1'b1));
    send_request(place_item(50, 40, 11, 22));
    send_request(place_item(1024, 10, -300, 300));
    send_request(place_item(2000, 60, 5, 5));
    send_request(write_item(3, 4095, -4096, 4095, 0, 1'b0));
    send_request(place_item(4095, 0, 1, 2));

    while (n_rand < 550) begin
      drain_answers();
      case (phase)
        0: begin cur_w = 0;    cur_h = 0;    end
        1: begin cur_w = 4095; cur_h = 4095; end
        2: begin cur_w = 1;    cur_h = 4095; end
        3: begin cur_w = 4095; cur_h = 1;    end
        4: begin cur_w = 1;    cur_h = 1;    end
        8, 14: begin
          cur_w = $urandom_range(0, 4095);
          cur_h = $urandom_range(0, 4095);
        end
        default: begin
          cur_w = $urandom_range(10, 220);
          cur_h = $urandom_range(10, 220);
        end
      endcase
      write_register(REG_DISPLAY_WIDTH, LEN_W'(cur_w));
      write_register(REG_DISPLAY_HEIGHT, LEN_W'(cur_h));
      // large displays make failed searches long, so keep those phases short
      count = (cur_w > 400 || cur_h > 400) ? 10 : 45;
      quiet_sender = ($urandom_range(0, 3) == 0) && phase != 5;
      for (int k = 0; k < count; k++) begin
        if (phase == 5 && k == 6) hold_out = 1'b1;
        if (phase == 6 && k == 20) drain_answers();
        send_request(rand_request());
        n_rand++;
      end
      phase++;
    end

    drain_answers();
    repeat (100) @(posedge clk);
    $display("Covered %0d transfers in (%0d placement requests) over %0d display settings;",
             n_items, n_place, phase);
    $display("checked %0d results, %0d of them edge spots found.",
             tracker.checked, tracker.spots_found);
    if (tracker.errors == 0 && tracker.due_answers.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
